### rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants for the segment/sphere crossing pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd4;

endpackage

### rtl/ssi_if.sv
// ----------------------------------------------------------------------------
// ssi segment and result channels
// Valid/ready channels carrying one segment item and one result item.
// ----------------------------------------------------------------------------
interface ssi_seg_if #(parameter int CW = ssi_pkg::COORD_WIDTH_DEF) ();
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface ssi_res_if #(parameter int CW = ssi_pkg::COORD_WIDTH_DEF) ();
  logic          valid;
  logic          ready;
  logic          hit;
  logic          start_inside;
  logic          end_inside;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  logic signed [CW-1:0] cross_z;
  logic          root_fault;
  modport source (output valid, hit, start_inside, end_inside, cross_x, cross_y,
                  cross_z, root_fault, input ready);
  modport sink (input valid, hit, start_inside, end_inside, cross_x, cross_y,
                cross_z, root_fault, output ready);
endinterface

### rtl/ssi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ssi_sqrt_cell
// One root bit of a digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module ssi_sqrt_cell #(
  parameter int RW = 16,
  parameter int QW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [RW-1:0] rad_in,
  input  logic [QW+1:0] rem_in,
  input  logic [QW-1:0] root_in,
  input  logic [PW-1:0] pay_in,
  output logic          vld_out,
  output logic [RW-1:0] rad_out,
  output logic [QW+1:0] rem_out,
  output logic [QW-1:0] root_out,
  output logic [PW-1:0] pay_out
);

  logic [QW+1:0] rem2;
  logic [QW+1:0] trial;
  logic          ge;

  // bring down the next two radicand bits and try root*4+1
  assign rem2  = {rem_in[QW-1:0], rad_in[RW-1 -: 2]};
  assign trial = {root_in, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[RW-3:0], 2'b00};
      rem_out  <= ge ? rem2 - trial : rem2;
      root_out <= {root_in[QW-2:0], ge};
      pay_out  <= pay_in;
    end
  end

endmodule

### rtl/ssi_div_cell.sv
// ----------------------------------------------------------------------------
// ssi_div_cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module ssi_div_cell #(
  parameter int AW    = 16,
  parameter int QW    = 8,
  parameter int PW    = 1,
  parameter bit SHIFT = 1'b1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [AW:0]   rem_in,
  input  logic [AW-1:0] a_in,
  input  logic [QW-1:0] q_in,
  input  logic [PW-1:0] pay_in,
  output logic          vld_out,
  output logic [AW:0]   rem_out,
  output logic [AW-1:0] a_out,
  output logic [QW-1:0] q_out,
  output logic [PW-1:0] pay_out
);

  logic [AW:0] rem2;
  logic        ge;

  // remainder stays below the divisor, so the shift never overflows
  assign rem2 = SHIFT ? {rem_in[AW-1:0], 1'b0} : rem_in;
  assign ge   = rem2 >= {1'b0, a_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem2 - {1'b0, a_in} : rem2;
      a_out   <= a_in;
      q_out   <= {q_in[QW-2:0], ge};
      pay_out <= pay_in;
    end
  end

endmodule

### rtl/segment_sphere_intersection.sv
// ----------------------------------------------------------------------------
// segment_sphere_intersection
// Inside tests of both segment endpoints against a sphere and, on a single
// crossing, the crossing point from a root of the segment quadratic.
//
//  channel | dir | handshake       | payload
//  seg     | in  | valid/ready     | start_x/y/z, end_x/y/z
//  res     | out | valid/ready     | hit, start/end_inside, cross_x/y/z, fault
//  cfg     | in  | cfg_we          | cfg_index, cfg_data
//
// one item per cycle while the output register is empty or being taken; the
// square root cell row gives one root bit per cell and the divider cell row
// one fraction bit per cell.
// the whole pipeline advances together whenever the output register is empty
// or being taken; seg.ready follows that enable.
// rst is synchronous and resets the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module segment_sphere_intersection #(
  parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ssi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ssi_seg_if.sink                       seg,
  ssi_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [ssi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  import ssi_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = CW + 1;        // coordinate difference
  localparam int PRW = 2 * DW;        // difference product
  localparam int SW  = 2 * CW + 4;    // dot products, cs
  localparam int HW  = 2 * CW + 3;    // h
  localparam int AW  = 2 * CW + 4;    // a
  localparam int K   = CW + 2;        // split point of wide products
  localparam int DDW = 4 * CW + 8;    // discriminant
  localparam int SQW = 2 * CW + 4;    // root bits
  localparam int RW  = 2 * SQW;       // radicand
  localparam int NW  = 2 * CW + 6;    // numerator
  localparam int QW  = F + 1;         // fraction
  localparam int XW  = CW + F + 3;    // interpolated coordinate
  localparam int GW  = 3 * CW + 3 * DW;
  localparam int SPW = GW + HW + AW + 4;
  localparam int DPW = GW + 6;

  logic en;
  assign en        = !res.valid || res.ready;
  assign seg.ready = en;

  // configuration
  logic signed [CW-1:0] centre [3];
  logic [CW-2:0]        radius;
  logic signed [CW-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre[0] <= '0;
      centre[1] <= '0;
      centre[2] <= '0;
      radius    <= (CW-1)'(1) << F;
      tol       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTRE_X: centre[0] <= cfg_data;
        CFG_CENTRE_Y: centre[1] <= cfg_data;
        CFG_CENTRE_Z: centre[2] <= cfg_data;
        CFG_RADIUS:   radius    <= cfg_data[CW-2:0];
        CFG_TOL:      tol       <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: differences
  logic signed [CW-1:0] in_s [3];
  logic signed [CW-1:0] in_e [3];
  assign in_s[0] = seg.start_x;
  assign in_s[1] = seg.start_y;
  assign in_s[2] = seg.start_z;
  assign in_e[0] = seg.end_x;
  assign in_e[1] = seg.end_y;
  assign in_e[2] = seg.end_z;

  logic                  s1_vld;
  logic signed [CW-1:0]  s1_s [3];
  logic signed [DW-1:0]  s1_w [3];
  logic signed [DW-1:0]  s1_u [3];
  logic signed [DW-1:0]  s1_v [3];
  logic [2*CW-3:0]       s1_r2;
  logic signed [SW-1:0]  s1_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_s[i] <= in_s[i];
        s1_w[i] <= DW'(in_s[i]) - DW'(centre[i]);
        s1_u[i] <= DW'(in_e[i]) - DW'(centre[i]);
        s1_v[i] <= DW'(in_e[i]) - DW'(in_s[i]);
      end
      s1_r2  <= radius * radius;
      s1_tol <= SW'(tol) <<< F;
    end
  end

  // stage 2: per-axis products
  logic                  s2_vld;
  logic signed [PRW-1:0] s2_ww [3];
  logic signed [PRW-1:0] s2_uu [3];
  logic signed [PRW-1:0] s2_vv [3];
  logic signed [PRW-1:0] s2_wv [3];
  logic [GW-1:0]         s2_geo;
  logic [2*CW-3:0]       s2_r2;
  logic signed [SW-1:0]  s2_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_ww[i] <= s1_w[i] * s1_w[i];
        s2_uu[i] <= s1_u[i] * s1_u[i];
        s2_vv[i] <= s1_v[i] * s1_v[i];
        s2_wv[i] <= s1_w[i] * s1_v[i];
      end
      s2_geo <= {s1_s[0], s1_s[1], s1_s[2], s1_v[0], s1_v[1], s1_v[2]};
      s2_r2  <= s1_r2;
      s2_tol <= s1_tol;
    end
  end

  // stage 3: dot products, inside tests
  logic signed [SW-1:0] cs_c, ce_c;
  logic [AW-1:0]        a_c;
  logic signed [HW-1:0] h_c;

  always_comb begin
    cs_c = SW'(s2_ww[0]) + SW'(s2_ww[1]) + SW'(s2_ww[2]) - SW'({1'b0, s2_r2});
    ce_c = SW'(s2_uu[0]) + SW'(s2_uu[1]) + SW'(s2_uu[2]) - SW'({1'b0, s2_r2});
    a_c  = AW'(s2_vv[0]) + AW'(s2_vv[1]) + AW'(s2_vv[2]);
    h_c  = HW'(s2_wv[0]) + HW'(s2_wv[1]) + HW'(s2_wv[2]);
  end

  logic                 s3_vld, s3_ins, s3_ine;
  logic signed [SW-1:0] s3_cs;
  logic [AW-1:0]        s3_a;
  logic signed [HW-1:0] s3_h;
  logic [GW-1:0]        s3_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ins <= cs_c <= s2_tol;
      s3_ine <= ce_c <= s2_tol;
      s3_cs  <= cs_c;
      s3_a   <= a_c;
      s3_h   <= h_c;
      s3_geo <= s2_geo;
    end
  end

  // stage 4: partial products of h*h and a*cs
  logic signed [HW-K-1:0] hh_c;
  logic [K-1:0]           hl_c, al_c, cl_c;
  logic signed [AW-K:0]   ah_c;
  logic signed [SW-K-1:0] ch_c;

  assign hh_c = s3_h[HW-1:K];
  assign hl_c = s3_h[K-1:0];
  assign ah_c = $signed({1'b0, s3_a[AW-1:K]});
  assign al_c = s3_a[K-1:0];
  assign ch_c = s3_cs[SW-1:K];
  assign cl_c = s3_cs[K-1:0];

  logic                        s4_vld, s4_ins, s4_ine;
  logic signed [2*(HW-K)-1:0]  s4_hhh;
  logic signed [HW+1:0]        s4_hhl;
  logic [2*K-1:0]              s4_hll;
  logic signed [AW+SW-2*K:0]   s4_ahch;
  logic signed [AW+1:0]        s4_ahcl;
  logic signed [SW+1:0]        s4_alch;
  logic [2*K-1:0]              s4_alcl;
  logic [AW-1:0]               s4_a;
  logic signed [HW-1:0]        s4_h;
  logic [GW-1:0]               s4_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hhh  <= hh_c * hh_c;
      s4_hhl  <= (HW+2)'(hh_c) * (HW+2)'($signed({1'b0, hl_c}));
      s4_hll  <= hl_c * hl_c;
      s4_ahch <= (AW+SW-2*K+1)'(ah_c) * (AW+SW-2*K+1)'(ch_c);
      s4_ahcl <= (AW+2)'(ah_c) * (AW+2)'($signed({1'b0, cl_c}));
      s4_alch <= (SW+2)'($signed({1'b0, al_c})) * (SW+2)'(ch_c);
      s4_alcl <= al_c * cl_c;
      s4_ins  <= s3_ins;
      s4_ine  <= s3_ine;
      s4_a    <= s3_a;
      s4_h    <= s3_h;
      s4_geo  <= s3_geo;
    end
  end

  // stage 5: recombine h*h and a*cs
  logic                  s5_vld, s5_ins, s5_ine;
  logic signed [DDW-1:0] s5_hsq, s5_acs;
  logic [AW-1:0]         s5_a;
  logic signed [HW-1:0]  s5_h;
  logic [GW-1:0]         s5_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hsq <= (DDW'(s4_hhh) <<< (2*K)) + (DDW'(s4_hhl) <<< (K+1))
                + DDW'($signed({1'b0, s4_hll}));
      s5_acs <= (DDW'(s4_ahch) <<< (2*K)) + ((DDW'(s4_ahcl) + DDW'(s4_alch)) <<< K)
                + DDW'($signed({1'b0, s4_alcl}));
      s5_ins <= s4_ins;
      s5_ine <= s4_ine;
      s5_a   <= s4_a;
      s5_h   <= s4_h;
      s5_geo <= s4_geo;
    end
  end

  // stage 6: discriminant
  logic                  s6_vld, s6_ins, s6_ine;
  logic signed [DDW-1:0] s6_d;
  logic [AW-1:0]         s6_a;
  logic signed [HW-1:0]  s6_h;
  logic [GW-1:0]         s6_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_d   <= s5_hsq - s5_acs;
      s6_ins <= s5_ins;
      s6_ine <= s5_ine;
      s6_a   <= s5_a;
      s6_h   <= s5_h;
      s6_geo <= s5_geo;
    end
  end

  // square root cell row
  logic           sq_vld  [SQW+1];
  logic [RW-1:0]  sq_rad  [SQW+1];
  logic [SQW+1:0] sq_rem  [SQW+1];
  logic [SQW-1:0] sq_root [SQW+1];
  logic [SPW-1:0] sq_pay  [SQW+1];

  logic s6_dneg;
  assign s6_dneg    = s6_d[DDW-1];
  assign sq_vld[0]  = s6_vld;
  assign sq_rad[0]  = s6_dneg ? '0 : $unsigned(s6_d);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = {s6_geo, s6_h, s6_a, s6_ins ^ s6_ine, s6_ins, s6_ine, s6_dneg};

  for (genvar g = 0; g < SQW; g++) begin : g_sqrt
    ssi_sqrt_cell #(.RW(RW), .QW(SQW), .PW(SPW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (sq_vld[g]),
      .rad_in   (sq_rad[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .pay_in   (sq_pay[g]),
      .vld_out  (sq_vld[g+1]),
      .rad_out  (sq_rad[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .pay_out  (sq_pay[g+1])
    );
  end

  logic [GW-1:0]        q_geo;
  logic signed [HW-1:0] q_h;
  logic [AW-1:0]        q_a;
  logic                 q_hit, q_ins, q_ine, q_dneg;
  assign {q_geo, q_h, q_a, q_hit, q_ins, q_ine, q_dneg} = sq_pay[SQW];

  // stage p1: both numerators
  logic                 p1_vld, p1_hit, p1_ins, p1_ine, p1_dneg;
  logic signed [NW-1:0] p1_n1, p1_n2;
  logic [AW-1:0]        p1_a;
  logic [GW-1:0]        p1_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= sq_vld[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_n1   <= $signed({2'b00, sq_root[SQW]}) - NW'(q_h);
      p1_n2   <= -NW'(q_h) - $signed({2'b00, sq_root[SQW]});
      p1_a    <= q_a;
      p1_hit  <= q_hit;
      p1_ins  <= q_ins;
      p1_ine  <= q_ine;
      p1_dneg <= q_dneg;
      p1_geo  <= q_geo;
    end
  end

  // stage p2: root choice and clamping
  logic signed [NW-1:0] a_ext, num_c;
  logic                 use1_c, neg_c, big_c;

  always_comb begin
    a_ext  = $signed({2'b00, p1_a});
    use1_c = !p1_n1[NW-1] && (p1_n1 <= a_ext);
    num_c  = use1_c ? p1_n1 : p1_n2;
    neg_c  = num_c[NW-1];
    big_c  = !neg_c && (num_c > a_ext);
  end

  logic                 p2_vld;
  logic [AW-1:0]        p2_num, p2_a;
  logic [DPW-1:0]       p2_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (en) begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_num <= (neg_c || big_c) ? '0 : num_c[AW-1:0];
      p2_a   <= p1_a;
      p2_pay <= {p1_geo, p1_hit, p1_ins, p1_ine, p1_dneg || neg_c || big_c,
                 neg_c || big_c, big_c};
    end
  end

  // divider cell row
  logic           dv_vld [QW+1];
  logic [AW:0]    dv_rem [QW+1];
  logic [AW-1:0]  dv_a   [QW+1];
  logic [QW-1:0]  dv_q   [QW+1];
  logic [DPW-1:0] dv_pay [QW+1];

  assign dv_vld[0] = p2_vld;
  assign dv_rem[0] = {1'b0, p2_num};
  assign dv_a[0]   = p2_a;
  assign dv_q[0]   = '0;
  assign dv_pay[0] = p2_pay;

  for (genvar g = 0; g < QW; g++) begin : g_div
    ssi_div_cell #(.AW(AW), .QW(QW), .PW(DPW), .SHIFT(g != 0)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (dv_vld[g]),
      .rem_in  (dv_rem[g]),
      .a_in    (dv_a[g]),
      .q_in    (dv_q[g]),
      .pay_in  (dv_pay[g]),
      .vld_out (dv_vld[g+1]),
      .rem_out (dv_rem[g+1]),
      .a_out   (dv_a[g+1]),
      .q_out   (dv_q[g+1]),
      .pay_out (dv_pay[g+1])
    );
  end

  // output stage: interpolate
  logic signed [CW-1:0] m_s [3];
  logic signed [DW-1:0] m_v [3];
  logic                 m_hit, m_ins, m_ine, m_fault, m_ovr, m_one;
  logic [QW-1:0]        lf;
  logic signed [XW-1:0] m_p [3];

  assign {m_s[0], m_s[1], m_s[2], m_v[0], m_v[1], m_v[2],
          m_hit, m_ins, m_ine, m_fault, m_ovr, m_one} = dv_pay[QW];
  assign lf = m_ovr ? (m_one ? QW'(1) << F : '0) : dv_q[QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_p[i] = (XW'(m_s[i]) <<< F) + XW'($signed({1'b0, lf})) * XW'(m_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit          <= m_hit;
      res.start_inside <= m_ins;
      res.end_inside   <= m_ine;
      res.root_fault   <= m_hit && m_fault;
      res.cross_x      <= m_hit ? m_p[0][F+CW-1:F] : '0;
      res.cross_y      <= m_hit ? m_p[1][F+CW-1:F] : '0;
      res.cross_z      <= m_hit ? m_p[2][F+CW-1:F] : '0;
    end
  end

  // checks
  a_hit_xor : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.hit == (res.start_inside ^ res.end_inside)))
    else $error("hit does not match inside flags");

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.hit) |-> (!res.root_fault && res.cross_x == '0 &&
                                 res.cross_y == '0 && res.cross_z == '0))
    else $error("miss result carries crossing data");

  a_take : assert property (@(posedge clk) disable iff (rst)
    (seg.valid && seg.ready) |=> s1_vld)
    else $error("accepted item lost at pipeline entry");

endmodule

### tb/tb_segment_sphere_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_sphere_intersection
// Drives segments into the crossing pipeline under bursty input and stalling
// output, predicts each result with exact wide integer arithmetic and checks
// every returned item in order, across several sphere and tolerance settings.
// ----------------------------------------------------------------------------
module tb_segment_sphere_intersection;
  import ssi_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 93;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 400;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    logic                 hit, start_in, end_in;
    logic signed [CW-1:0] cx, cy, cz;
    logic                 fault;
  } crossing_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  ssi_seg_if #(.CW(CW)) seg ();
  ssi_res_if #(.CW(CW)) res ();

  segment_sphere_intersection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .seg(seg), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // sphere settings as the block should hold them
  logic signed [CW-1:0] sph_centre [3];
  logic [CW-2:0]        sph_radius;
  logic signed [CW-1:0] sph_tol;

  segment_t  pending_segs [$];
  crossing_t expected_crossings [$];
  int mismatches = 0;
  int checked = 0;
  int hits_seen = 0;
  int faults_seen = 0;
  int accepted = 0;
  int cyc = 0;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc,
               expected_crossings.size());
      $display("FAIL segment_sphere_intersection");
      $finish;
    end
  end

  function automatic wide_t sx(logic signed [CW-1:0] x);
    return {{(256-CW){x[CW-1]}}, x};
  endfunction

  function automatic crossing_t predict_crossing(segment_t sg);
    wide_t s [3], w [3], u [3], v [3];
    wide_t e, r2, cs, ce, tol, a, h, d, sq, num, t, p, one;
    logic [FB:0] lf, tl;
    crossing_t r;
    s[0] = sx(sg.sx); s[1] = sx(sg.sy); s[2] = sx(sg.sz);
    one = 1;
    for (int i = 0; i < 3; i++) begin
      e = (i == 0) ? sx(sg.ex) : (i == 1) ? sx(sg.ey) : sx(sg.ez);
      w[i] = s[i] - sx(sph_centre[i]);
      u[i] = e - sx(sph_centre[i]);
      v[i] = e - s[i];
    end
    r2 = {{(257-CW){1'b0}}, sph_radius};
    r2 = r2 * r2;
    cs = w[0]*w[0] + w[1]*w[1] + w[2]*w[2] - r2;
    ce = u[0]*u[0] + u[1]*u[1] + u[2]*u[2] - r2;
    tol = sx(sph_tol) <<< FB;
    r = '0;
    r.start_in = (cs <= tol);
    r.end_in = (ce <= tol);
    r.hit = r.start_in ^ r.end_in;
    if (r.hit) begin
      a = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      h = w[0]*v[0] + w[1]*v[1] + w[2]*v[2];
      d = h*h - a*cs;
      sq = 0;
      lf = '0;
      if (d < 0) begin
        r.fault = 1'b1;
      end else begin
        for (int b = 110; b >= 0; b--) begin
          t = sq | (one << b);
          if (t*t <= d) sq = t;
        end
      end
      num = sq - h;
      if (num < 0 || num > a) num = -h - sq;
      if (num < 0) begin
        r.fault = 1'b1;
      end else if (num > a) begin
        r.fault = 1'b1;
        lf = 1 << FB;
      end else begin
        for (int b = FB; b >= 0; b--) begin
          tl = lf | (1 << b);
          if ({{(256-FB-1){1'b0}}, tl} * a <= (num <<< FB)) lf = tl;
        end
      end
      t = {{(256-FB-1){1'b0}}, lf};
      p = ((s[0] <<< FB) + t*v[0]) >>> FB; r.cx = p[CW-1:0];
      p = ((s[1] <<< FB) + t*v[1]) >>> FB; r.cy = p[CW-1:0];
      p = ((s[2] <<< FB) + t*v[2]) >>> FB; r.cz = p[CW-1:0];
    end
    return r;
  endfunction

  // driver: bursts of items with random gaps
  logic took;
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (seg.valid && !took) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      seg.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_segs.size() > 0) begin
      segment_t sg;
      sg = pending_segs.pop_front();
      {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z} <= sg;
      seg.valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      seg.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    took <= 1'b0;
    if (!rst && seg.valid && seg.ready) begin
      took <= 1'b1;
      accepted <= accepted + 1;
      expected_crossings.push_back(predict_crossing({seg.start_x, seg.start_y,
        seg.start_z, seg.end_x, seg.end_y, seg.end_z}));
    end
  end

  // receiver: random stall modes (always ready, random, mostly stalled), plus one long hold
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 256 == 0) rx_mode <= $urandom_range(0, 2);
    if (!hold_done && accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    if (hold_left > 0 || (!hold_done && accepted >= HOLD_AT))
      res.ready <= 1'b0;
    else if (rx_mode == 0)
      res.ready <= 1'b1;
    else if (rx_mode == 1)
      res.ready <= $urandom_range(0, 1);
    else
      res.ready <= ($urandom_range(0, 4) == 0);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      crossing_t got, want;
      got = {res.hit, res.start_inside, res.end_inside, res.cross_x, res.cross_y,
             res.cross_z, res.root_fault};
      checked <= checked + 1;
      hits_seen <= hits_seen + got.hit;
      faults_seen <= faults_seen + got.fault;
      if (expected_crossings.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("result with nothing expected: %p", got);
      end else begin
        want = expected_crossings.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch at item %0d\n  expected %p\n  actual   %p",
                     checked, want, got);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      CFG_CENTRE_X: sph_centre[0] = data;
      CFG_CENTRE_Y: sph_centre[1] = data;
      CFG_CENTRE_Z: sph_centre[2] = data;
      CFG_RADIUS:   sph_radius = data[CW-2:0];
      CFG_TOL:      sph_tol = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_segs.size() > 0 || seg.valid || expected_crossings.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic add_seg(longint ax, longint ay, longint az,
                         longint bx, longint by, longint bz);
    segment_t sg;
    sg.sx = ax; sg.sy = ay; sg.sz = az;
    sg.ex = bx; sg.ey = by; sg.ez = bz;
    pending_segs.push_back(sg);
  endtask

  // coordinate offset from the centre; scale 0 is inside, 1 is outside
  function automatic longint near_off(int scale);
    longint rq, m;
    rq = sph_radius;
    if (scale == 0) begin
      m = rq / 2;
      return longint'($urandom_range(0, 32'(2*m))) - m;
    end
    m = longint'($urandom_range(0, 32'(2*rq + 65536))) + rq;
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  task automatic add_point_pair(bit start_in, bit end_in);
    longint p [6];
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'(sph_centre[i]) + near_off(start_in ? 0 : 1);
      p[3+i] = longint'(sph_centre[i]) + near_off(end_in ? 0 : 1);
    end
    add_seg(p[0], p[1], p[2], p[3], p[4], p[5]);
  endtask

  task automatic add_random_items(int n);
    int k;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      if (k < 38) add_point_pair(1, 0);
      else if (k < 76) add_point_pair(0, 1);
      else if (k < 84) add_point_pair(1, 1);
      else if (k < 90) add_point_pair(0, 0);
      else if (k < 92) begin
        longint x, y, z;
        x = $urandom; y = $urandom; z = $urandom;
        add_seg(x, y, z, x, y, z);
      end else begin
        add_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  localparam longint MAXC = 64'sh7fffffff;
  localparam longint MINC = -64'sh80000000;
  localparam longint ONE = 65536;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    seg.valid = 1'b0;
    res.ready = 1'b0;
    sph_centre[0] = 0; sph_centre[1] = 0; sph_centre[2] = 0;
    sph_radius = 1 << FB;
    sph_tol = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items against the reset sphere (unit radius at origin)
    add_seg(0, 0, 0, 2*ONE, 0, 0);
    add_seg(2*ONE, 0, 0, 0, 0, 0);
    add_seg(0, ONE/2, 0, 0, 0, 3*ONE);
    add_seg(ONE, 0, 0, 3*ONE, 0, 0);
    add_seg(0, 0, 0, 0, ONE/3, 0);
    add_seg(3*ONE, 3*ONE, 0, 4*ONE, -5*ONE, 0);
    add_seg(ONE/4, ONE/4, ONE/4, ONE/4, ONE/4, ONE/4);
    add_seg(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    add_seg(MINC, 0, 0, MAXC, 0, 0);
    add_seg(0, 0, 0, MAXC, MAXC, MAXC);
    add_seg(MINC, MINC, MINC, 0, 0, 0);
    add_seg(-1, -1, -1, MINC, MAXC, MINC);
    add_seg(0, 0, 0, 1, 0, 0);
    add_seg(0, 0, 0, 0, 0, ONE + 1);
    add_seg(-ONE/2, 0, 0, -ONE/2, 5*ONE, 0);
    wait_idle();

    // large tolerance: ends just outside the true sphere count as inside
    write_reg(CFG_TOL, 32'(3*ONE));
    // register indexes beyond the list are ignored
    write_reg(3'd5, 32'hdead_beef);
    write_reg(3'd7, 32'hffff_ffff);
    add_seg(ONE + ONE/2, 0, 0, 5*ONE, 0, 0);
    add_seg(0, ONE + ONE/4, 0, 0, ONE + ONE/2, 0);
    add_seg(5*ONE, 5*ONE, 0, ONE, ONE/2, 0);
    add_seg(0, 0, ONE + ONE/3, 0, ONE + ONE/3, ONE + ONE/3);
    add_random_items(150);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      logic [CW-1:0] rad, tol;
      case (ph)
        0: begin rad = 32'h8000_0000 | 32'(4*ONE); tol = 0; end
        1: begin rad = 32'h7fff_ffff; tol = 32'h7fff_ffff; end
        2: begin rad = 0; tol = 0; end
        3: begin rad = $urandom_range(1, 64*ONE); tol = 32'h8000_0000; end
        4: begin rad = $urandom_range(1, 256); tol = $urandom_range(0, 1024); end
        5: begin rad = $urandom_range(ONE, 1000*ONE); tol = $urandom; end
        6: begin rad = $urandom; tol = -($urandom_range(0, 50*ONE)); end
        default: begin rad = $urandom_range(ONE, 8*ONE); tol = 0; end
      endcase
      write_reg(CFG_CENTRE_X, (ph == 1) ? 32'h7fff_ffff : (ph == 2) ? 32'h8000_0000
                              : $urandom);
      write_reg(CFG_CENTRE_Y, (ph == 1) ? 32'h8000_0000 : $urandom);
      write_reg(CFG_CENTRE_Z, (ph == 2) ? 32'h7fff_ffff : $urandom_range(0, 1) ?
                              $urandom : 0);
      write_reg(CFG_RADIUS, rad);
      write_reg(CFG_TOL, tol);
      add_random_items(100);
      // pause the sender until everything has drained, same settings
      while (pending_segs.size() > 0 || seg.valid || expected_crossings.size() > 0)
        @(posedge clk);
      add_random_items(100);
      wait_idle();
    end

    $display("checked %0d results (%0d hits, %0d root faults) over 10 sphere settings",
             checked, hits_seen, faults_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("PASS segment_sphere_intersection");
    end else begin
      $display("FAIL segment_sphere_intersection");
    end
    $finish;
  end

endmodule
